// ===== hw/rtl/ste_pkg.sv =====
// ============================================================================
// Scalar tween engine package
// Shared types, register indexes, curve constants and the 16-bit saturation.
// ============================================================================
`default_nettype none

package ste_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_ACTIVATE   = 2'd1,
        REQ_DEACTIVATE = 2'd2,
        REQ_RESET      = 2'd3
    } t_req;

    // Curve selection
    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_WAVE   = 2'd1,
        MODE_PULSE  = 2'd2,
        MODE_EASE   = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ANIM_MODE         = 3'd0,
        CFG_MIN_VALUE         = 3'd1,
        CFG_MAX_VALUE         = 3'd2,
        CFG_DURATION          = 3'd3,
        CFG_LOOP_ENABLE       = 3'd4,
        CFG_RESET_ON_INACTIVE = 3'd5,
        CFG_RESET_ON_COMPLETE = 3'd6
    } t_cfg_idx;

    // Port widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int PROG_OUT_W  = 17;

    // Width of the pre-saturation value sums
    localparam int SAT_W = 22;

    // Quarter-wave sine polynomial coefficients (Q15)
    localparam logic [16:0] SIN_A = 17'd51472;
    localparam logic [16:0] SIN_B = 17'd21024;
    localparam logic [16:0] SIN_C = 17'd2320;
    localparam logic [16:0] SIN_HALF_TURN = 17'd32768;

    // Reset values of the configuration registers
    localparam logic signed [15:0] MAX_VALUE_RST = 16'sd32767;
    localparam logic [15:0]        DURATION_RST  = 16'd1000;

    // Clamp a wide signed value to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -SAT_W'(32768)) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scalar_tween_engine.sv =====
// ============================================================================
// Scalar tween engine
// One animation channel: progress accumulation and four value curves.
// ============================================================================
// Usage: configuration words arrive on the cfg channel (index, data), which
// is always ready; write it only while the channel is idle. Request words
// arrive on the s_axis channel: tuser holds the request kind, tdata the
// timestep. Each request gives exactly one result word on m_axis: tdata holds
// the value and the progress, tuser the active flag, tlast marks a tick that
// completed a cycle.
// Activate, deactivate, reset and inactive ticks go from acceptance straight
// to the output stage. An active tick runs a restoring divider that retires
// one quotient bit per cycle over NW = max(16+F, 2F) bits (F = fraction bits),
// then reuses one multiplier: the span product for linear; the square, the
// polynomial terms and the span product for wave and pulse; the square, a
// second division and the span product for ease in-out. A tick that completes
// the cycle skips the multiplier. s_axis tready is high only while no word is in work.
// Reset (synchronous, active low) loads the configuration defaults and
// clears progress, value and the active flag. A stalled receiver holds the
// result in the output register; the next word may be accepted meanwhile,
// but its result waits until the held one is taken.
// ============================================================================
`default_nettype none

module scalar_tween_engine #(
    parameter int PROGRESS_FRAC_BITS = 16,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ste_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ste_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Request stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [ste_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] timestep
    input  wire logic [ste_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,   // [1:0] req_type
    // Result stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [ste_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,   // [15:0] anim_value,
                                                                  // [32:16] progress_out,
                                                                  // [39:33] zero
    output logic                                o_m_axis_tuser,   // [0] is_active
    output logic                                o_m_axis_tlast    // cycle_done
);

    localparam int F  = PROGRESS_FRAC_BITS;
    localparam int L  = $clog2(SINE_TABLE_ENTRIES);
    localparam int PW = F + 1;
    localparam int NW = (16 + F > 2 * F) ? 16 + F : 2 * F;
    localparam int DW = (F + 1 > 16) ? F + 1 : 16;
    localparam int CW = $clog2(NW);
    localparam int MW = (F + 2 > 18) ? F + 2 : 18;

    localparam logic [PW-1:0] ONE_PW = {1'b1, {F{1'b0}}};
    localparam logic [NW-1:0] ONE_Q  = {{(NW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [NW:0]   PMAX_W = {{(NW-F){1'b0}}, {(F+1){1'b1}}};
    localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_DQ   = 6'b000100,
        S_MUL  = 6'b001000,
        S_USE  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        ST_LIN,
        ST_SQ,
        ST_EASE_D,
        ST_X2,
        ST_T1,
        ST_T2,
        ST_S,
        ST_SD
    } t_step;

    // Configuration registers
    ste_pkg::t_mode     r_mode;
    logic signed [15:0] r_min;
    logic signed [15:0] r_max;
    logic [15:0]        r_dur;
    logic               r_loop;
    logic               r_rst_inactive;
    logic               r_rst_complete;

    // Sequencer and datapath registers
    t_state                 r_state, n_state;
    t_step                  r_step, n_step;
    logic                   r_div_ease, n_div_ease;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_quo, n_quo;
    logic [DW-1:0]          r_rem, n_rem;
    logic [DW-1:0]          r_den, n_den;
    logic [F-1:0]           r_p, n_p;
    logic [1:0]             r_quad, n_quad;
    logic [16:0]            r_x, n_x;
    logic [16:0]            r_x2, n_x2;
    logic signed [MW-1:0]   r_ma, n_ma;
    logic signed [MW-1:0]   r_mb, n_mb;
    logic signed [2*MW-1:0] r_prod;

    // Channel state
    logic [PW-1:0]      r_prog, n_prog;
    logic signed [15:0] r_value, n_value;
    logic               r_active, n_active;
    logic               r_done, n_done;

    // Output register
    logic                            r_ovalid, n_ovalid;
    logic [ste_pkg::M_TDATA_W-1:0]   r_otdata, n_otdata;
    logic                            r_oactive, n_oactive;
    logic                            r_olast, n_olast;

    // Combinational datapath
    logic                   s_accept;
    ste_pkg::t_req          req;
    logic [DW:0]            div_trial;
    logic                   div_ge;
    logic [DW:0]            div_diff;
    logic [NW:0]            prog_sum;
    logic [PW-1:0]          p_sat;
    logic [F+L-1:0]         p_scaled;
    logic [L-1:0]           k_idx;
    logic [15:0]            phase;
    logic [16:0]            x_raw;
    logic [16:0]            x_pos;
    logic signed [16:0]     d_val;
    logic signed [16:0]     sum_mm;
    logic signed [15:0]     mid_val;
    logic signed [15:0]     rest_val;
    logic signed [15:0]     end_val;
    logic [F-1:0]           sq;
    logic signed [F+2:0]    den_s;
    logic [F:0]             e_val;
    logic [16:0]            prod_q15;
    logic signed [17:0]     s_val;
    logic signed [36:0]     wave_acc;
    logic signed [15:0]     frac_val;
    logic signed [15:0]     wave_val;
    logic signed [15:0]     pulse_val;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign req             = ste_pkg::t_req'(i_s_axis_tuser);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_oactive;
    assign o_m_axis_tlast  = r_olast;

    // Write configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= ste_pkg::MODE_LINEAR;
            r_min          <= '0;
            r_max          <= ste_pkg::MAX_VALUE_RST;
            r_dur          <= ste_pkg::DURATION_RST;
            r_loop         <= 1'b0;
            r_rst_inactive <= 1'b0;
            r_rst_complete <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ste_pkg::t_cfg_idx'(i_cfg_index))
                ste_pkg::CFG_ANIM_MODE:         r_mode <= ste_pkg::t_mode'(i_cfg_data[1:0]);
                ste_pkg::CFG_MIN_VALUE:         r_min <= $signed(i_cfg_data);
                ste_pkg::CFG_MAX_VALUE:         r_max <= $signed(i_cfg_data);
                ste_pkg::CFG_DURATION:          r_dur <= i_cfg_data;
                ste_pkg::CFG_LOOP_ENABLE:       r_loop <= i_cfg_data[0];
                ste_pkg::CFG_RESET_ON_INACTIVE: r_rst_inactive <= i_cfg_data[0];
                ste_pkg::CFG_RESET_ON_COMPLETE: r_rst_complete <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // One restoring divider step: compare the shifted remainder with the divisor
    assign div_trial = {r_rem, r_quo[NW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_den});
    assign div_diff  = div_trial - {1'b0, r_den};

    // Saturating progress update from the increment quotient
    assign prog_sum = NW'(r_prog) + {1'b0, r_quo};
    assign p_sat    = (prog_sum > PMAX_W) ? PMAX_W[PW-1:0] : prog_sum[PW-1:0];

    // Sine table index and phase (Q16 of a turn), quadrant and quarter position
    assign p_scaled = {p_sat[F-1:0], {L{1'b0}}};
    assign k_idx    = p_scaled[F+L-1:F];
    assign phase    = (r_mode == ste_pkg::MODE_WAVE) ? {k_idx, {(16-L){1'b0}}}
                                                     : {1'b0, k_idx, {(15-L){1'b0}}};
    assign x_raw    = {2'b00, phase[13:0], 1'b0};
    assign x_pos    = phase[14] ? (ste_pkg::SIN_HALF_TURN - x_raw) : x_raw;

    // Span, midpoint, rest and end values
    assign d_val    = 17'(r_max) - 17'(r_min);
    assign sum_mm   = 17'(r_min) + 17'(r_max);
    assign mid_val  = 16'(sum_mm >>> 1);
    assign rest_val = (r_mode == ste_pkg::MODE_WAVE) ? mid_val : r_min;
    assign end_val  = (r_mode == ste_pkg::MODE_WAVE || r_mode == ste_pkg::MODE_PULSE)
                      ? mid_val : r_max;

    // Ease in-out: square, denominator and clamped quotient
    assign sq    = r_prod[2*F-1:F];
    assign den_s = $signed((F+3)'({sq, 1'b0})) - $signed((F+3)'({r_p, 1'b0}))
                   + $signed((F+3)'(ONE_PW));
    assign e_val = (r_quo > ONE_Q) ? ONE_Q[F:0] : r_quo[F:0];

    // Polynomial products scaled by 2^-15
    assign prod_q15 = r_prod[31:15];
    assign s_val    = r_quad[1] ? -$signed({1'b0, prod_q15}) : $signed({1'b0, prod_q15});

    // Final value forms
    assign frac_val  = ste_pkg::sat16(ste_pkg::SAT_W'($signed(r_prod[F+19:F]))
                                      + ste_pkg::SAT_W'(r_min));
    assign wave_acc  = (37'(sum_mm) <<< 15) + 37'($signed(r_prod[35:0]));
    assign wave_val  = ste_pkg::sat16(ste_pkg::SAT_W'($signed(wave_acc[36:16])));
    assign pulse_val = ste_pkg::sat16(ste_pkg::SAT_W'($signed(r_prod[35:15]))
                                      + ste_pkg::SAT_W'(r_min));

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_div_ease = r_div_ease;
        n_cnt      = r_cnt;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_den      = r_den;
        n_p        = r_p;
        n_quad     = r_quad;
        n_x        = r_x;
        n_x2       = r_x2;
        n_ma       = r_ma;
        n_mb       = r_mb;
        n_prog     = r_prog;
        n_value    = r_value;
        n_active   = r_active;
        n_done     = r_done;
        n_ovalid   = r_ovalid;
        n_otdata   = r_otdata;
        n_oactive  = r_oactive;
        n_olast    = r_olast;

        // Drop the held result once taken
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_done  = 1'b0;
                    n_state = S_OUT;
                    case (req)
                        ste_pkg::REQ_ACTIVATE:   n_active = 1'b1;
                        ste_pkg::REQ_DEACTIVATE: n_active = 1'b0;
                        ste_pkg::REQ_RESET: begin
                            n_prog  = '0;
                            n_value = rest_val;
                        end
                        ste_pkg::REQ_TICK: begin
                            if (!r_active) begin
                                if ((!r_prog[F] && r_rst_inactive)
                                    || (r_prog[F] && r_rst_complete)) begin
                                    n_prog  = '0;
                                    n_value = rest_val;
                                end
                            end else begin
                                // Start increment = timestep * 2^F / duration
                                n_quo      = NW'({i_s_axis_tdata, {F{1'b0}}});
                                n_rem      = '0;
                                n_den      = (r_dur == '0) ? DW'(1) : DW'(r_dur);
                                n_cnt      = '0;
                                n_div_ease = 1'b0;
                                n_state    = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_DIV: begin
                n_rem = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
                n_quo = {r_quo[NW-2:0], div_ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DQ;
                end
            end

            S_DQ: begin
                if (r_div_ease) begin
                    n_ma    = MW'(e_val);
                    n_mb    = MW'(d_val);
                    n_step  = ST_EASE_D;
                    n_state = S_MUL;
                end else if (p_sat[F]) begin
                    // Cycle complete: hold the end value
                    n_value = end_val;
                    n_done  = 1'b1;
                    n_state = S_OUT;
                    if (r_loop) begin
                        n_prog = '0;
                    end else begin
                        n_active = 1'b0;
                        n_prog   = ONE_PW;
                    end
                end else begin
                    n_prog  = p_sat;
                    n_p     = p_sat[F-1:0];
                    n_quad  = phase[15:14];
                    n_x     = x_pos;
                    n_state = S_MUL;
                    case (r_mode)
                        ste_pkg::MODE_EASE: begin
                            n_ma   = MW'(p_sat[F-1:0]);
                            n_mb   = MW'(p_sat[F-1:0]);
                            n_step = ST_SQ;
                        end
                        ste_pkg::MODE_WAVE, ste_pkg::MODE_PULSE: begin
                            n_ma   = MW'(x_pos);
                            n_mb   = MW'(x_pos);
                            n_step = ST_X2;
                        end
                        default: begin
                            n_ma   = MW'(p_sat[F-1:0]);
                            n_mb   = MW'(d_val);
                            n_step = ST_LIN;
                        end
                    endcase
                end
            end

            S_MUL: begin
                n_state = S_USE;
            end

            S_USE: begin
                n_state = S_MUL;
                case (r_step)
                    ST_LIN, ST_EASE_D: begin
                        n_value = frac_val;
                        n_state = S_OUT;
                    end
                    ST_SQ: begin
                        // Start ease quotient = sq * 2^F / den
                        n_quo      = NW'({sq, {F{1'b0}}});
                        n_rem      = '0;
                        n_den      = (den_s <= 0) ? DW'(1) : DW'(den_s[F:0]);
                        n_cnt      = '0;
                        n_div_ease = 1'b1;
                        n_state    = S_DIV;
                    end
                    ST_X2: begin
                        n_x2   = prod_q15;
                        n_ma   = MW'(ste_pkg::SIN_C);
                        n_mb   = MW'(prod_q15);
                        n_step = ST_T1;
                    end
                    ST_T1: begin
                        n_ma   = MW'(ste_pkg::SIN_B - prod_q15);
                        n_mb   = MW'(r_x2);
                        n_step = ST_T2;
                    end
                    ST_T2: begin
                        n_ma   = MW'(ste_pkg::SIN_A - prod_q15);
                        n_mb   = MW'(r_x);
                        n_step = ST_S;
                    end
                    ST_S: begin
                        n_ma   = MW'(s_val);
                        n_mb   = MW'(d_val);
                        n_step = ST_SD;
                    end
                    ST_SD: begin
                        n_value = (r_mode == ste_pkg::MODE_WAVE) ? wave_val : pulse_val;
                        n_state = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end

            S_OUT: begin
                // Load the result word once the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_otdata  = {7'b0, ste_pkg::PROG_OUT_W'(r_prog), r_value};
                    n_oactive = r_active;
                    n_olast   = r_done;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prog   <= '0;
            r_value  <= '0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prog   <= n_prog;
            r_value  <= n_value;
            r_active <= n_active;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_div_ease <= n_div_ease;
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_p        <= n_p;
        r_quad     <= n_quad;
        r_x        <= n_x;
        r_x2       <= n_x2;
        r_ma       <= n_ma;
        r_mb       <= n_mb;
        r_otdata   <= n_otdata;
        r_oactive  <= n_oactive;
        r_olast    <= n_olast;
        if (r_state == S_MUL) begin
            r_prod <= r_ma * r_mb;
        end
    end

`ifndef NO_ASSERTIONS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_prog_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= ONE_PW)
        else $error("stored progress above one");

    a_tick_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (req == ste_pkg::REQ_TICK) && r_active) |=> (r_state == S_DIV))
        else $error("active tick did not start the divider");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && !r_loop) |-> !o_m_axis_tuser)
        else $error("completed word without loop still active");
`endif

endmodule

`default_nettype wire

// ===== tb/scalar_tween_engine_test.sv =====
// ----------------------------------------------------------------------------
// Scalar tween engine testbench
// Drives request words and register writes into the tween channel, keeps its
// own model of progress, value and the active flag, and checks every result
// word field by field as it leaves the block. Sender bursts and receiver
// stalls are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scalar_tween_engine_test;

    localparam int  ITEM_TARGET  = 1650;
    localparam int  QUIET_LIMIT  = 4000;
    localparam int  TAIL_CYCLES  = 100;
    localparam int  PRINT_LIMIT  = 40;
    // index past the last register, writes to it must be ignored
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

    // ------------------------------------------------------------------------
    // Expected-result tracker: models the channel and checks result words
    // ------------------------------------------------------------------------
    class tween_checker;
        localparam longint FRAC      = 16;
        localparam longint ONE       = 64'sd1 << FRAC;
        localparam longint PROG_MAX  = (64'sd1 << (FRAC + 1)) - 1;
        localparam longint N_ENTRIES = 256;

        typedef struct {
            logic [15:0] value;
            logic [16:0] progress;
            logic        active;
            logic        done;
        } t_word;

        t_word  expected_words[$];
        int     errors;

        // configuration copy
        ste_pkg::t_mode mode = ste_pkg::MODE_LINEAR;
        longint min_v    = 0;
        longint max_v    = 32767;
        longint dur      = 1000;
        bit     loop_en  = 1'b0;
        bit     rst_inact = 1'b0;
        bit     rst_comp = 1'b0;

        // channel state
        longint progress = 0;
        longint value    = 0;
        bit     active   = 1'b0;

        function bit running();
            return active;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                ste_pkg::CFG_ANIM_MODE:         mode = ste_pkg::t_mode'(data[1:0]);
                ste_pkg::CFG_MIN_VALUE:         min_v = $signed(data);
                ste_pkg::CFG_MAX_VALUE:         max_v = $signed(data);
                ste_pkg::CFG_DURATION:          dur = longint'(data);
                ste_pkg::CFG_LOOP_ENABLE:       loop_en = data[0];
                ste_pkg::CFG_RESET_ON_INACTIVE: rst_inact = data[0];
                ste_pkg::CFG_RESET_ON_COMPLETE: rst_comp = data[0];
                default: ;
            endcase
        endfunction

        function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // Q15 sine of a Q16 phase, quarter-wave polynomial
        function longint sine_q15(longint ph);
            longint quad;
            longint x;
            longint x2;
            longint t;
            longint s;
            quad = (ph >>> 14) % 4;
            x = (ph % 16384) * 2;
            if (quad == 1 || quad == 3) x = 32768 - x;
            x2 = (x * x) >>> 15;
            t = 21024 - ((2320 * x2) >>> 15);
            t = 51472 - ((t * x2) >>> 15);
            s = (t * x) >>> 15;
            return (quad >= 2) ? -s : s;
        endfunction

        function longint mid_level();
            return (min_v + max_v) >>> 1;
        endfunction

        function longint rest_level();
            return (mode == ste_pkg::MODE_WAVE) ? mid_level() : min_v;
        endfunction

        function longint curve_level(longint p);
            longint d;
            longint k;
            longint s;
            longint sq;
            longint den;
            longint e;
            d = max_v - min_v;
            k = (p * N_ENTRIES) >>> FRAC;
            case (mode)
                ste_pkg::MODE_WAVE: begin
                    s = sine_q15((k * 65536) / N_ENTRIES);
                    return clamp16(((min_v + max_v) * 32768 + s * d) >>> 16);
                end
                ste_pkg::MODE_PULSE: begin
                    s = sine_q15((k * 32768) / N_ENTRIES);
                    return clamp16(min_v + ((s * d) >>> 15));
                end
                ste_pkg::MODE_EASE: begin
                    sq = (p * p) >>> FRAC;
                    den = 2 * sq - 2 * p + ONE;
                    if (den <= 0) den = 1;
                    e = (sq << FRAC) / den;
                    if (e > ONE) e = ONE;
                    return clamp16(min_v + ((e * d) >>> FRAC));
                end
                default: return clamp16(min_v + ((p * d) >>> FRAC));
            endcase
        endfunction

        // advance the channel by one accepted request word
        function void predict_request(ste_pkg::t_req req, logic [15:0] ts);
            t_word  w;
            bit     done;
            bit     finished;
            longint step_dur;
            longint p;
            done = 1'b0;
            case (req)
                ste_pkg::REQ_ACTIVATE:   active = 1'b1;
                ste_pkg::REQ_DEACTIVATE: active = 1'b0;
                ste_pkg::REQ_RESET: begin
                    progress = 0;
                    value = rest_level();
                end
                default: begin
                    if (!active) begin
                        finished = (progress >= ONE);
                        if ((!finished && rst_inact) || (finished && rst_comp)) begin
                            value = rest_level();
                            progress = 0;
                        end
                    end else begin
                        step_dur = (dur == 0) ? 1 : dur;
                        p = progress + ((longint'(ts) << FRAC) / step_dur);
                        if (p > PROG_MAX) p = PROG_MAX;
                        if (p >= ONE) begin
                            // cycle complete: hold the end value
                            value = (mode == ste_pkg::MODE_WAVE ||
                                     mode == ste_pkg::MODE_PULSE) ? mid_level() : max_v;
                            done = 1'b1;
                            if (loop_en) begin
                                progress = 0;
                            end else begin
                                active = 1'b0;
                                progress = ONE;
                            end
                        end else begin
                            progress = p;
                            value = curve_level(p);
                        end
                    end
                end
            endcase
            w.value = value[15:0];
            w.progress = progress[16:0];
            w.active = active;
            w.done = done;
            expected_words.insert(expected_words.size(), w);
        endfunction

        task report(string field, longint got, longint want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field,
                         got, want);
        endtask

        task check_result(logic [39:0] data, logic act, logic last);
            t_word w;
            if (expected_words.size() == 0) begin
                report("unexpected word", data[15:0], 0);
            end else begin
                w = expected_words.pop_front();
                if (data[15:0] !== w.value)
                    report("anim_value", $signed(data[15:0]), $signed(w.value));
                if (data[32:16] !== w.progress)
                    report("progress_out", data[32:16], w.progress);
                if (data[39:33] !== 7'd0)
                    report("tdata padding", data[39:33], 0);
                if (act !== w.active)
                    report("is_active", act, w.active);
                if (last !== w.done)
                    report("cycle_done", last, w.done);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [ste_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ste_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [ste_pkg::S_TDATA_W-1:0]  i_s_axis_tdata;   // [15:0] timestep
    logic [ste_pkg::S_TUSER_W-1:0]  i_s_axis_tuser;   // [1:0] req_type
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [ste_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;   // [15:0] anim_value,
                                                      // [32:16] progress_out
    logic                           o_m_axis_tuser;   // [0] is_active
    logic                           o_m_axis_tlast;   // cycle_done

    scalar_tween_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    tween_checker tween = new;
    int           items_sent;
    int           burst_left;
    int           quiet_cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Send one request word, with a random gap whenever a burst runs out
    task automatic push_item(input ste_pkg::t_req req, input logic [15:0] ts);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata <= 16'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                                       $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= req;
        i_s_axis_tdata <= ts;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tween.predict_request(req, ts);
        items_sent++;
    endtask

    // Hold the sender until every expected word has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tween.pending() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tween.write_reg(idx, data);
    endtask

    // Write all seven registers, then drop valid
    task automatic set_config(input ste_pkg::t_mode mode, input logic [15:0] min_v,
                              input logic [15:0] max_v, input logic [15:0] dur,
                              input bit loop_en, input bit rst_inact, input bit rst_comp);
        write_reg(ste_pkg::CFG_ANIM_MODE, 16'(mode));
        write_reg(ste_pkg::CFG_MIN_VALUE, min_v);
        write_reg(ste_pkg::CFG_MAX_VALUE, max_v);
        write_reg(ste_pkg::CFG_DURATION, dur);
        write_reg(ste_pkg::CFG_LOOP_ENABLE, 16'(loop_en));
        write_reg(ste_pkg::CFG_RESET_ON_INACTIVE, 16'(rst_inact));
        write_reg(ste_pkg::CFG_RESET_ON_COMPLETE, 16'(rst_comp));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random phase: fresh settings, then mostly activate-and-tick runs
    task automatic random_phase(input int n_items);
        logic [15:0] dur;
        longint      step;
        int          pick;
        case ($urandom_range(0, 9))
            0:       dur = 16'd0;
            1:       dur = 16'd1;
            2:       dur = 16'hffff;
            3:       dur = 16'($urandom_range(2, 50));
            default: dur = 16'($urandom);
        endcase
        set_config(ste_pkg::t_mode'($urandom_range(0, 3)), pick_level(), pick_level(), dur,
                   1'($urandom), 1'($urandom), 1'($urandom));
        // timestep scale so that a cycle takes a handful of ticks
        step = ((dur == 0) ? 64'd2 : 2 * longint'(dur)) / $urandom_range(3, 24);
        if (step < 1) step = 1;
        if (step > 65535) step = 65535;
        repeat (n_items) begin
            pick = $urandom_range(0, 19);
            if (!tween.running()) begin
                if (pick < 15)      push_item(ste_pkg::REQ_ACTIVATE, 16'($urandom));
                else if (pick < 17) push_item(ste_pkg::REQ_TICK, 16'($urandom));
                else if (pick < 19) push_item(ste_pkg::REQ_RESET, 16'($urandom));
                else                push_item(ste_pkg::REQ_DEACTIVATE, 16'($urandom));
            end else if (pick < 17) begin
                if ($urandom_range(0, 7) == 0)
                    push_item(ste_pkg::REQ_TICK, 16'($urandom));
                else
                    push_item(ste_pkg::REQ_TICK, 16'($urandom_range(0, int'(step))));
            end else if (pick == 17) begin
                push_item(ste_pkg::REQ_RESET, 16'($urandom));
            end else if (pick == 18) begin
                push_item(ste_pkg::REQ_DEACTIVATE, 16'($urandom));
            end else begin
                push_item(ste_pkg::REQ_ACTIVATE, 16'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes every so often
    // ------------------------------------------------------------------------
    initial begin : receiver
        int rx_left;
        int rx_mode;
        int rx_count;
        i_m_axis_tready = 1'b0;
        rx_left = 0;
        rx_mode = 0;
        rx_count = 0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_count++;
            case (rx_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= 1'($urandom);
                2:       i_m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: i_m_axis_tready <= ((rx_count % 7) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                tween.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = ste_pkg::REQ_TICK;
        items_sent = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle tick, full run, stop at one, reactivate when finished
        push_item(ste_pkg::REQ_TICK, 16'd100);
        push_item(ste_pkg::REQ_ACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd500);
        push_item(ste_pkg::REQ_TICK, 16'hffff);
        push_item(ste_pkg::REQ_TICK, 16'd10);
        push_item(ste_pkg::REQ_ACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd0);
        push_item(ste_pkg::REQ_RESET, 16'd0);
        push_item(ste_pkg::REQ_DEACTIVATE, 16'd0);

        // wave, widest span, zero duration, looping, both rest flags
        wait_drain();
        write_reg(CFG_IDX_SPARE, 16'hffff);
        set_config(ste_pkg::MODE_WAVE, 16'h8000, 16'h7fff, 16'd0, 1'b1, 1'b1, 1'b1);
        push_item(ste_pkg::REQ_ACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd1);
        push_item(ste_pkg::REQ_DEACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd5);

        // pulse, inverted span, longest duration, return to rest once finished
        wait_drain();
        set_config(ste_pkg::MODE_PULSE, 16'h7fff, 16'h8000, 16'hffff, 1'b0, 1'b0, 1'b1);
        push_item(ste_pkg::REQ_ACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd32768);
        push_item(ste_pkg::REQ_TICK, 16'hffff);
        push_item(ste_pkg::REQ_TICK, 16'd7);

        // ease in-out in three steps that stop just short of one
        wait_drain();
        set_config(ste_pkg::MODE_EASE, 16'h8000, 16'h7fff, 16'd3, 1'b0, 1'b0, 1'b0);
        push_item(ste_pkg::REQ_ACTIVATE, 16'd0);
        push_item(ste_pkg::REQ_TICK, 16'd1);
        push_item(ste_pkg::REQ_TICK, 16'd1);
        push_item(ste_pkg::REQ_TICK, 16'd1);
        push_item(ste_pkg::REQ_TICK, 16'hffff);
        push_item(ste_pkg::REQ_RESET, 16'd0);

        while (items_sent < ITEM_TARGET) begin
            wait_drain();
            random_phase($urandom_range(20, 80));
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tween.errors == 0 && tween.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ste_pkg.sv
hw/rtl/scalar_tween_engine.sv
tb/scalar_tween_engine_test.sv
